// ===== sv/breakpoint_table_interpolator_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_DEFINES_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("breakpoint table interpolator: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("breakpoint table interpolator: check failed");

`endif

// ===== sv/bti_pkg.sv =====
`timescale 1ns / 1ps
package bti_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam logic [30:0] DefaultSizeReset = 31'h7FFF_FFFF;
  localparam int unsigned EntryCountW = 7;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;

  localparam logic signed [31:0] SizeMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SizeMin = -32'sh8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_WR,
    ST_Q_RD,
    ST_Q_CMP,
    ST_Q_RDH,
    ST_Q_RDL,
    ST_Q_LDL,
    ST_Q_CHK,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_FIN
  } bti_state_e;

  // Request to the divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } bti_div_req_t;

endpackage

// ===== sv/bti_div.sv =====
`timescale 1ns / 1ps
module bti_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bti_pkg::bti_div_req_t req_i,
  output logic                  done_o,
  output logic [63:0]           quot_o
);
  import bti_pkg::*;

  // Restoring division, one quotient bit per cycle.
  logic [32:0] rem_q, rem_d;
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_q[31:0], dvd_q[63]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      dvd_d = req_i.dividend;
      den_d = req_i.divisor;
      cnt_d = 7'd64;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? trial - {1'b0, den_q} : trial;
      dvd_d = {dvd_q[62:0], fits};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ===== sv/breakpoint_table_interpolator.sv =====
`timescale 1ns / 1ps
// Breakpoint table interpolator. The block holds up to TABLE_DEPTH (key, size) pairs in
// signed Q16.16, sorted by key, in one synchronous memory, and takes one item at a time:
// an item is taken when start is high and busy is low, and its single result appears on
// the result ports for exactly one cycle with done_o high. The receiver cannot hold a
// result off, so it must take every result in the cycle that shows it. A clear or an
// unused command answers in the next cycle. An insert scans down from the top of the
// table, reading and comparing one entry at a time and moving larger entries up by
// one, and then writes the new entry into the slot that is left. This read-then-write
// loop over the memory sets its length. A query runs a binary search of at most
// ceil(log2(count+1)) steps, reads two neighboring entries, multiplies once and then
// divides in a bit-serial divider; the divider dominates. A query on an empty table
// answers in the next cycle, and one that needs no interpolation skips the multiplier
// and the divider. There is no clearing pass after reset: only entries below the
// count are ever used.
module breakpoint_table_interpolator #(
  parameter int unsigned TABLE_DEPTH = bti_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd_i,
  input  logic signed [31:0]  param_value_i,
  input  logic signed [31:0]  size_value_i,
  input  logic                cfg_we_i,
  input  logic [30:0]         cfg_wdata_i,
  output logic                done_o,
  output logic signed [31:0]  size_out_o,
  output logic                table_full_o,
  output logic                saturated_o,
  output logic [bti_pkg::EntryCountW-1:0] entry_count_o
);
  import bti_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  bti_state_e state_q, state_d;

  logic [30:0]        dflt_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;     // insert slot, or search lower bound
  logic [CW-1:0]      hi_q, hi_d;       // search upper bound, then right index
  logic [CW-1:0]      mid_q, mid_d;
  logic signed [31:0] pv_q, pv_d;
  logic signed [31:0] sv_q, sv_d;
  logic signed [31:0] ku_q, ku_d, su_q, su_d, kl_q, kl_d, sl_q, sl_d;
  logic [31:0]        adl_q, adl_d, du_q, du_d, den_q, den_d;
  logic               neg_q, neg_d;
  logic [63:0]        prod_q, prod_d;

  logic               done_q, done_d, full_q, full_d, sat_q, sat_d;
  logic signed [31:0] out_q, out_d;
  logic [EntryCountW-1:0] ecnt_q, ecnt_d;

  // Table memory: key in the upper half, size in the lower half.
  logic [63:0]   mem [TABLE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  logic signed [31:0] rd_key, rd_size;
  assign rd_key  = rdata_q[63:32];
  assign rd_size = rdata_q[31:0];

  logic accept;
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Search and scan helpers.
  logic [CW-1:0] idx_m1, mid_c, lo_nx, hi_nx, h_idx, l_idx;
  logic          key_lt, key_gt;
  logic [CW:0]   mid_sum;
  assign idx_m1  = idx_q - CW'(1);
  assign mid_sum = {1'b0, idx_q} + {1'b0, hi_q};
  assign mid_c   = mid_sum[CW:1];
  assign key_lt  = rd_key < pv_q;
  assign key_gt  = rd_key > pv_q;
  assign lo_nx   = key_lt ? mid_q + CW'(1) : idx_q;
  assign hi_nx   = key_lt ? hi_q : mid_q;
  // Right entry is the first key not below the query, clamped to the last entry.
  assign h_idx   = (idx_q == count_q) ? count_q - CW'(1) : idx_q;
  assign l_idx   = (hi_q == '0) ? '0 : hi_q - CW'(1);

  // Interpolation arithmetic.
  logic signed [32:0] dl, du, dk;
  assign dl = 33'(su_q) - 33'(sl_q);
  assign du = 33'(pv_q) - 33'(kl_q);
  assign dk = 33'(ku_q) - 33'(kl_q);

  bti_div_req_t div_req;
  logic         div_done;
  logic [63:0]  quot;

  assign div_req.start    = (state_q == ST_DIV_GO);
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = den_q;

  bti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  logic               q_big;
  logic signed [36:0] q_signed, q_sum;
  assign q_big    = (|quot[63:35]) || (quot[34] && (|quot[33:0]));
  assign q_signed = neg_q ? -$signed({2'b00, quot[34:0]}) : $signed({2'b00, quot[34:0]});
  assign q_sum    = q_signed + 37'(sl_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CmdInsert && count_q != CW'(TABLE_DEPTH)) begin
            state_d = (count_q == '0) ? ST_INS_WR : ST_INS_RD;
          end else if (cmd_i == CmdQuery && count_q != '0) begin
            state_d = ST_Q_RD;
          end
        end
      end
      ST_INS_RD:  state_d = ST_INS_CMP;
      ST_INS_CMP: begin
        if (key_gt && idx_m1 != '0) begin
          state_d = ST_INS_RD;
        end else begin
          state_d = ST_INS_WR;
        end
      end
      ST_INS_WR:  state_d = ST_IDLE;
      ST_Q_RD:    state_d = ST_Q_CMP;
      ST_Q_CMP:   state_d = (lo_nx == hi_nx) ? ST_Q_RDH : ST_Q_RD;
      ST_Q_RDH:   state_d = ST_Q_RDL;
      ST_Q_RDL:   state_d = ST_Q_LDL;
      ST_Q_LDL:   state_d = ST_Q_CHK;
      ST_Q_CHK:   state_d = (hi_q == '0 || kl_q == ku_q) ? ST_IDLE : ST_MUL;
      ST_MUL:     state_d = ST_DIV_GO;
      ST_DIV_GO:  state_d = ST_DIV;
      ST_DIV:     state_d = div_done ? ST_FIN : ST_DIV;
      ST_FIN:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory access and result.
  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    pv_d      = pv_q;
    sv_d      = sv_q;
    ku_d      = ku_q;
    su_d      = su_q;
    kl_d      = kl_q;
    sl_d      = sl_q;
    adl_d     = adl_q;
    du_d      = du_q;
    den_d     = den_q;
    neg_d     = neg_q;
    prod_d    = prod_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = {pv_q, sv_q};
    mem_raddr = idx_m1[AW-1:0];
    done_d    = 1'b0;
    out_d     = out_q;
    full_d    = full_q;
    sat_d     = sat_q;
    ecnt_d    = ecnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pv_d  = param_value_i;
          sv_d  = size_value_i;
          idx_d = (cmd_i == CmdInsert) ? count_q : '0;
          hi_d  = count_q;
          out_d = '0;
          full_d = 1'b0;
          sat_d  = 1'b0;
          ecnt_d = EntryCountW'(count_q);
          case (cmd_i)
            CmdClear: begin
              count_d = '0;
              ecnt_d  = '0;
              done_d  = 1'b1;
            end
            CmdInsert: begin
              if (count_q == CW'(TABLE_DEPTH)) begin
                full_d = 1'b1;
                done_d = 1'b1;
              end
            end
            CmdQuery: begin
              if (count_q == '0) begin
                out_d  = $signed({1'b0, dflt_q});
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_INS_RD: begin
        mem_raddr = idx_m1[AW-1:0];
      end
      ST_INS_CMP: begin
        if (key_gt) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q;
          idx_d     = idx_m1;
        end
      end
      ST_INS_WR: begin
        mem_we  = 1'b1;
        count_d = count_q + CW'(1);
        ecnt_d  = EntryCountW'(count_q + CW'(1));
        done_d  = 1'b1;
      end
      ST_Q_RD: begin
        mid_d     = mid_c;
        mem_raddr = mid_c[AW-1:0];
      end
      ST_Q_CMP: begin
        idx_d = lo_nx;
        hi_d  = hi_nx;
      end
      ST_Q_RDH: begin
        hi_d      = h_idx;
        mem_raddr = h_idx[AW-1:0];
      end
      ST_Q_RDL: begin
        ku_d      = rd_key;
        su_d      = rd_size;
        mem_raddr = l_idx[AW-1:0];
      end
      ST_Q_LDL: begin
        kl_d = rd_key;
        sl_d = rd_size;
      end
      ST_Q_CHK: begin
        if (hi_q == '0 || kl_q == ku_q) begin
          out_d  = sl_q;
          done_d = 1'b1;
        end else begin
          neg_d = dl[32];
          adl_d = dl[32] ? 32'(-dl) : dl[31:0];
          du_d  = du[31:0];
          den_d = dk[31:0];
        end
      end
      ST_MUL: begin
        prod_d = adl_q * du_q;
      end
      ST_FIN: begin
        done_d = 1'b1;
        if (q_big) begin
          sat_d = 1'b1;
          out_d = neg_q ? SizeMin : SizeMax;
        end else if (q_sum > 37'(SizeMax)) begin
          sat_d = 1'b1;
          out_d = SizeMax;
        end else if (q_sum < 37'(SizeMin)) begin
          sat_d = 1'b1;
          out_d = SizeMin;
        end else begin
          out_d = q_sum[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      dflt_q  <= DefaultSizeReset;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    pv_q   <= pv_d;
    sv_q   <= sv_d;
    ku_q   <= ku_d;
    su_q   <= su_d;
    kl_q   <= kl_d;
    sl_q   <= sl_d;
    adl_q  <= adl_d;
    du_q   <= du_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    out_q  <= out_d;
    full_q <= full_d;
    sat_q  <= sat_d;
    ecnt_q <= ecnt_d;
  end

  assign done_o        = done_q;
  assign size_out_o    = out_q;
  assign table_full_o  = full_q;
  assign saturated_o   = sat_q;
  assign entry_count_o = ecnt_q;

endmodule

// ===== sv/bti_checker.sv =====
`timescale 1ns / 1ps
`include "breakpoint_table_interpolator_defines.svh"
module bti_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [1:0]         cmd_i,
  input logic               done_o,
  input logic signed [31:0] size_out_o,
  input logic               table_full_o,
  input logic               saturated_o,
  input logic [bti_pkg::EntryCountW-1:0] entry_count_o
);
  import bti_pkg::*;

  // A result is only shown once the block has gone back to idle.
  `BTI_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // A clear answers in the next cycle with an empty table.
  `BTI_ASSERT_NEXT(a_clear, clk_i, rst_ni, start && !busy && cmd_i == CmdClear, done_o && entry_count_o == '0 && size_out_o == '0)
  // A dropped insert carries no size and no saturation.
  `BTI_ASSERT_NOW(a_full, clk_i, rst_ni, done_o && table_full_o, size_out_o == '0 && !saturated_o)

endmodule

bind breakpoint_table_interpolator bti_checker u_bti_checker (.*);

// ===== verif/breakpoint_table_interpolator_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the breakpoint table interpolator.
// An initial block fills a queue of pending items phase by phase. A clocked driver
// presents them at the falling edge, with random gaps. A clocked monitor on the rising
// edge does two things. It predicts the result of each accepted item with its own copy
// of the table. It also checks every result strobe against the oldest prediction.
// The default size register is written only while the block is idle.
module breakpoint_table_interpolator_test;
  import bti_pkg::*;

  localparam int unsigned Depth = DefaultDepth;
  // Command code that the block leaves unused.
  localparam logic [1:0] CmdSpare = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] param;
    logic signed [31:0] size;
  } bp_item_t;

  typedef struct packed {
    logic signed [31:0] size_out;
    logic               table_full;
    logic               saturated;
    logic [6:0]         entry_count;
  } bp_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              cmd_i = CmdClear;
  logic signed [31:0]      param_value_i = '0;
  logic signed [31:0]      size_value_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [30:0]             cfg_wdata_i = '0;
  logic                    done_o;
  logic signed [31:0]      size_out_o;
  logic                    table_full_o;
  logic                    saturated_o;
  logic [EntryCountW-1:0]  entry_count_o;

  breakpoint_table_interpolator #(.TABLE_DEPTH(Depth)) DUT (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .param_value_i, .size_value_i,
    .cfg_we_i, .cfg_wdata_i, .done_o, .size_out_o, .table_full_o, .saturated_o,
    .entry_count_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the block's table and register.
  logic signed [31:0] shadow_keys [Depth];
  logic signed [31:0] shadow_sizes [Depth];
  int unsigned        shadow_count = 0;
  logic [30:0]        shadow_default = DefaultSizeReset;

  bp_item_t   pending_items [$];
  bp_result_t expected_results [$];
  int         error_count = 0;
  int         gap_left = 0;
  bit         no_idle = 0;
  bit         took_last = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d (time %0t)", what, got, want, $realtime);
    error_count++;
  endtask

  // Interpolated size at parameter u over the shadow table.
  function automatic logic signed [31:0] lookup_size(input longint u, output logic sat);
    int unsigned lo, hi, left;
    longint      u0, u1, l0, l1, dl, q;
    longint unsigned mag, den, qm;
    bit          neg;
    sat = 1'b0;
    if (shadow_count == 0) return {1'b0, shadow_default};
    lo = 0;
    while (lo < shadow_count && longint'(shadow_keys[lo]) < u) lo++;
    hi = (lo < shadow_count - 1) ? lo : shadow_count - 1;
    left = (hi > 0) ? hi - 1 : 0;
    u0 = shadow_keys[left];
    u1 = shadow_keys[hi];
    l0 = shadow_sizes[left];
    l1 = shadow_sizes[hi];
    if (hi == left || u0 == u1) return l0[31:0];
    // Past this point u > u0 and u1 > u0.
    dl = l1 - l0;
    neg = dl < 0;
    mag = longint'(neg ? -dl : dl) * longint'(u - u0);
    den = u1 - u0;
    qm = mag / den;
    if (qm > (64'd1 << 34)) begin
      sat = 1'b1;
      return neg ? SizeMin : SizeMax;
    end
    q = neg ? -longint'(qm) : longint'(qm);
    q += l0;
    if (q > longint'(SizeMax)) begin
      sat = 1'b1;
      return SizeMax;
    end
    if (q < longint'(SizeMin)) begin
      sat = 1'b1;
      return SizeMin;
    end
    return q[31:0];
  endfunction

  // Applies one item to the shadow table and returns the result it should produce.
  function automatic bp_result_t table_step(input bp_item_t it);
    bp_result_t  r;
    int unsigned pos;
    logic        sat;
    r = '0;
    case (it.cmd)
      CmdClear: begin
        shadow_count = 0;
      end
      CmdInsert: begin
        if (shadow_count >= Depth) begin
          r.table_full = 1'b1;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_keys[pos] <= it.param) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_sizes[i] = shadow_sizes[i-1];
          end
          shadow_keys[pos] = it.param;
          shadow_sizes[pos] = it.size;
          shadow_count++;
        end
      end
      CmdQuery: begin
        r.size_out = lookup_size(longint'(it.param), sat);
        r.saturated = sat;
      end
      default: begin
      end
    endcase
    r.entry_count = shadow_count[6:0];
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: presents the oldest pending item; holds it until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !took_last)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cmd_i <= pending_items[0].cmd;
        param_value_i <= pending_items[0].param;
        size_value_i <= pending_items[0].size;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
    took_last = 1'b0;
  end

  // Monitor: checks result strobes first, then predicts for a newly accepted item.
  always @(posedge clk_i) begin
    bp_item_t   it;
    bp_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, size_out", size_out_o, 0);
        end else begin
          want = expected_results.pop_front();
          if (size_out_o !== want.size_out)
            report_mismatch("size_out", size_out_o, want.size_out);
          if (table_full_o !== want.table_full)
            report_mismatch("table_full", table_full_o, want.table_full);
          if (saturated_o !== want.saturated)
            report_mismatch("saturated", saturated_o, want.saturated);
          if (entry_count_o !== want.entry_count)
            report_mismatch("entry_count", entry_count_o, want.entry_count);
        end
      end
      if (start && !busy) begin
        it.cmd = cmd_i;
        it.param = param_value_i;
        it.size = size_value_i;
        want = table_step(it);
        expected_results = {expected_results, want};
        void'(pending_items.pop_front());
        gap_left = pick_gap();
        took_last = 1'b1;
      end
    end
  end

  task automatic add_item(input logic [1:0] c, input logic signed [31:0] p,
                          input logic signed [31:0] s);
    bp_item_t it;
    it.cmd = c;
    it.param = p;
    it.size = s;
    pending_items = {pending_items, it};
  endtask

  task automatic wait_idle();
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  // Register write while the block is idle; the shadow follows at the same edge.
  task automatic write_default(input logic [30:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    shadow_default = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A 32-bit value drawn from extremes, a narrow band or the full range.
  function automatic logic signed [31:0] pick_value(input bit narrow);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SizeMax;
    if (r == 1) return SizeMin;
    if (narrow && r < 8) return $signed($urandom_range(0, 16)) - 8;
    return $urandom;
  endfunction

  initial begin
    logic signed [31:0] keys [$];
    int   made, n_ins, n_q;
    bit   narrow;
    logic signed [31:0] p;
    int   r;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, one entry, equal keys, saturation both ways, unused command.
    add_item(CmdQuery, 0, 0);
    add_item(CmdInsert, SizeMin, 100);
    add_item(CmdQuery, SizeMin, 0);
    add_item(CmdQuery, SizeMax, 0);
    add_item(CmdInsert, 0, 0);
    add_item(CmdInsert, 0, 5);
    add_item(CmdQuery, 0, 0);
    add_item(CmdQuery, 1, 0);
    add_item(CmdQuery, -32'sd1000, 0);
    add_item(CmdInsert, 1000, SizeMax);
    add_item(CmdQuery, SizeMax, 0);
    add_item(CmdInsert, 1001, SizeMin);
    add_item(CmdQuery, SizeMax, 0);
    add_item(CmdQuery, 1000, 0);
    add_item(CmdSpare, SizeMax, SizeMin);
    add_item(CmdQuery, 500, SizeMax);
    add_item(CmdClear, SizeMax, SizeMax);
    add_item(CmdQuery, 7, 0);
    wait_idle();
    write_default('0);
    add_item(CmdQuery, SizeMin, 0);
    wait_idle();

    made = 20;
    while (made < 1350) begin
      r = $urandom_range(0, 3);
      if (r == 0) write_default('0);
      else if (r == 1) write_default(31'h7FFF_FFFF);
      else write_default(31'($urandom));
      no_idle = ($urandom_range(0, 4) == 0);
      narrow = $urandom_range(0, 1);
      keys.delete();
      add_item(CmdClear, $urandom, $urandom);
      // Mostly small tables; now and then fill past the top to hit the full flag.
      n_ins = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 12);
      n_q = $urandom_range(4, 20);
      for (int i = 0; i < n_ins + n_q; i++) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          add_item($urandom_range(0, 1) ? CmdSpare : CmdClear, $urandom, $urandom);
          if (r == 0) keys.delete();
        end else if (i < n_ins) begin
          p = (keys.size() > 0 && $urandom_range(0, 3) == 0) ?
              keys[$urandom_range(0, keys.size() - 1)] : pick_value(narrow);
          keys = {keys, p};
          add_item(CmdInsert, p, pick_value(narrow));
        end else begin
          if (keys.size() > 0 && $urandom_range(0, 2) != 0)
            p = keys[$urandom_range(0, keys.size() - 1)] + $signed($urandom_range(0, 6)) - 3;
          else
            p = pick_value(narrow);
          add_item(CmdQuery, p, $urandom);
        end
      end
      made += n_ins + n_q + 1;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bti_pkg.sv
sv/bti_div.sv
sv/breakpoint_table_interpolator.sv
sv/bti_checker.sv
verif/breakpoint_table_interpolator_test.sv
